// ===== hw/rtl/ukst_pkg.sv =====
// Shared types and codes for the unique key set table.
package ukst_pkg;

  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_DUP     = 2'd1,
    ST_REJECT  = 2'd2,
    ST_REMOVED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } cmd_t;

endpackage

// ===== hw/rtl/ukst_ctrl.sv =====
// Controller state machine for the unique key set table.
module ukst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output ukst_pkg::cmd_t cmd
);

  ukst_pkg::state_t state_r;
  ukst_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ukst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: an item accepted in idle or in update goes to compare.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ukst_pkg::S_IDLE: begin
        if (start) state_nxt = ukst_pkg::S_CMP;
      end
      ukst_pkg::S_CMP: begin
        state_nxt = ukst_pkg::S_UPD;
      end
      ukst_pkg::S_UPD: begin
        state_nxt = start ? ukst_pkg::S_CMP : ukst_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ukst_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy        = 1'b0;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      ukst_pkg::S_IDLE: begin
        cmd.load = start;
      end
      ukst_pkg::S_CMP: begin
        busy        = 1'b1;
        cmd.compare = 1'b1;
      end
      ukst_pkg::S_UPD: begin
        cmd.update = 1'b1;
        cmd.load   = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ukst_dp.sv =====
// Datapath of the unique key set table: entry registers, compare, update.
module ukst_dp #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ukst_pkg::cmd_t                  cmd,
  input  logic                            in_op,
  input  logic [ukst_pkg::KEY_W-1:0]      in_key,
  output logic                            out_valid,
  output logic [ukst_pkg::STATUS_W-1:0]   out_status,
  output logic [ukst_pkg::SLOT_W-1:0]     out_slot,
  output logic [ukst_pkg::COUNT_W-1:0]    out_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [ukst_pkg::KEY_W-1:0] key_r;
  logic                       op_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [DEPTH-1:0]           match_r;
  logic [ukst_pkg::KEY_W-1:0] entries_r [DEPTH];

  logic [IW-1:0]              hit_idx;
  logic                       hit;
  logic                       full;
  logic                       do_add;
  logic                       do_remove;
  ukst_pkg::status_t          status_nxt;
  logic [IW-1:0]              slot_nxt;
  logic [31:0]                slot_w;
  logic [31:0]                count_w;

  // Latch the item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
      op_r  <= in_op;
    end
  end

  // First matching live entry.
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IW'(i);
    end
  end

  assign hit       = |match_r;
  assign full      = (count_r == FULL_CNT);
  assign do_add    = cmd.update && (op_r == ukst_pkg::OP_INSERT) && !hit && !full;
  assign do_remove = cmd.update && (op_r == ukst_pkg::OP_REMOVE) && hit;

  always_comb begin
    status_nxt = ukst_pkg::ST_REJECT;
    slot_nxt   = '0;
    count_nxt  = count_r;
    if (op_r == ukst_pkg::OP_INSERT) begin
      if (hit) begin
        status_nxt = ukst_pkg::ST_DUP;
        slot_nxt   = hit_idx;
      end else if (!full) begin
        status_nxt = ukst_pkg::ST_ADDED;
        slot_nxt   = count_r[IW-1:0];
        count_nxt  = count_r + CW'(1);
      end
    end else if (hit) begin
      status_nxt = ukst_pkg::ST_REMOVED;
      slot_nxt   = hit_idx;
      count_nxt  = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  // One cell per slot: compare, append and shift-down.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ent
    localparam logic [CW-1:0] IDX  = CW'(gi);
    localparam logic [CW-1:0] NEXT = CW'(gi + 1);

    logic shift_en;
    assign shift_en = do_remove && (IDX >= {{(CW-IW){1'b0}}, hit_idx}) && (NEXT < count_r);

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        match_r[gi] <= (entries_r[gi] == key_r) && (IDX < count_r);
      end
    end

    if (gi < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (do_add && (count_r == IDX)) begin
          entries_r[gi] <= key_r;
        end else if (shift_en) begin
          entries_r[gi] <= entries_r[gi+1];
        end
      end
    end else begin : g_top
      // The top slot never takes a shifted entry.
      always_ff @(posedge clk) begin
        if (do_add && (count_r == IDX)) begin
          entries_r[gi] <= key_r;
        end
      end
    end
  end

  assign slot_w  = 32'(slot_nxt);
  assign count_w = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status <= status_nxt;
      out_slot   <= slot_w[ukst_pkg::SLOT_W-1:0];
      out_count  <= count_w[ukst_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/unique_key_set_table.sv =====
// Top level of the unique key set table: a duplicate-free set of rectangle keys.
//
//   channel  ports                                         handshake
//   -------  --------------------------------------------  ------------------------
//   input    in_op, in_pos_x, in_pos_y, in_rect_height,    taken when start && !busy
//            in_rect_length
//   result   out_status, out_slot, out_count               one cycle, out_valid high
//
// Each item has a compare cycle that registers the match vector of all live entries
// against the key, and an update cycle that picks the first match, appends or
// shifts the entry registers and loads the result registers. The result shows on
// the ports in the cycle after the update. A new item can be taken during the
// update cycle, so items run back to back.
// Reset clears the entry count and the controller; entry contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module unique_key_set_table #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic signed [15:0]   in_pos_x,
  input  logic signed [15:0]   in_pos_y,
  input  logic        [15:0]   in_rect_height,
  input  logic        [15:0]   in_rect_length,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [3:0]           out_slot,
  output logic [4:0]           out_count
);

  ukst_pkg::cmd_t cmd;
  logic [ukst_pkg::KEY_W-1:0] key;

  // Pack the key as length, height, y, x; fields compare as raw bit patterns.
  assign key = {in_rect_length, in_rect_height, in_pos_y, in_pos_x};

  // Sequence compare and update.
  ukst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the entries, search them and apply the operation.
  ukst_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_op),
    .in_key     (key),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_count  (out_count)
  );

endmodule

// ===== dv/unique_key_set_table_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the unique key set table, checked against a predictor.
module unique_key_set_table_tb;

  localparam int DEPTH       = 16;
  localparam int POOL_SIZE   = 24;    // a little over DEPTH so full and duplicates both occur
  localparam int RAND_ITEMS  = 1225;
  localparam int MAX_GAP     = 12;
  localparam int STALL_LIMIT = 500;   // cycles with no item taken and no result seen
  localparam int TAIL_CYCLES = 8;
  localparam int REPORT_MAX  = 10;

  // One pending item: the key is packed length, height, y, x from the top down.
  typedef struct {
    logic        op;
    logic [63:0] key;
    int          gap;
  } key_item_t;

  typedef struct packed {
    ukst_pkg::status_t status;
    logic [3:0]        slot;
    logic [4:0]        count;
  } set_result_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               in_op          = ukst_pkg::OP_INSERT;
  logic signed [15:0] in_pos_x       = '0;
  logic signed [15:0] in_pos_y       = '0;
  logic        [15:0] in_rect_height = '0;
  logic        [15:0] in_rect_length = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [3:0]         out_slot;
  logic [4:0]         out_count;

  key_item_t   item_queue[$];
  set_result_t expected_results[$];

  // Predictor copy of the set: live keys sit below live_count.
  logic [63:0] key_store[DEPTH];
  int          live_count = 0;

  key_item_t   cur_item;
  bit          cur_loaded     = 1'b0;
  int          gap_left       = 0;
  bit          item_taken     = 1'b0;
  int          items_taken    = 0;
  int          items_total    = 0;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;

  unique_key_set_table #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_rect_height(in_rect_height),
    .in_rect_length(in_rect_length),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_count     (out_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Search the live keys for the first match, then append, reject or remove and
  // close the gap. Only live keys move down; the vacated top slot stays stale.
  function automatic set_result_t apply_key_op(input logic op, input logic [63:0] key);
    set_result_t res;
    int          hit;
    int          i;
    hit = -1;
    for (i = 0; i < live_count; i++) begin
      if (hit < 0 && key_store[i] == key) hit = i;
    end
    res.slot = '0;
    if (op == ukst_pkg::OP_INSERT) begin
      if (hit >= 0) begin
        res.status = ukst_pkg::ST_DUP;
        res.slot   = hit[3:0];
      end else if (live_count >= DEPTH) begin
        res.status = ukst_pkg::ST_REJECT;
      end else begin
        res.status           = ukst_pkg::ST_ADDED;
        res.slot             = live_count[3:0];
        key_store[live_count] = key;
        live_count++;
      end
    end else begin
      if (hit < 0) begin
        // not found shares the reject code; op tells it apart from full
        res.status = ukst_pkg::ST_REJECT;
      end else begin
        res.status = ukst_pkg::ST_REMOVED;
        res.slot   = hit[3:0];
        for (i = hit; i + 1 < live_count; i++) key_store[i] = key_store[i + 1];
        live_count--;
      end
    end
    res.count = live_count[4:0];
    return res;
  endfunction

  // Queue an item with an idle gap drawn cycle by cycle at the given percentage.
  task automatic add_item(input logic op, input logic [63:0] key, input int idle_pct);
    key_item_t it;
    it.op  = op;
    it.key = key;
    it.gap = 0;
    while (it.gap < MAX_GAP && $urandom_range(99) < idle_pct) it.gap++;
    item_queue.push_back(it);
  endtask

  // Driver: change inputs on the falling edge. Hold an item until it is taken,
  // then idle out the next item's gap and present it. Keep start high across
  // back-to-back items so it is never dropped and raised in the same step.
  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (!cur_loaded && item_queue.size() > 0) begin
        cur_item   = item_queue.pop_front();
        cur_loaded = 1'b1;
        gap_left   = cur_item.gap;
      end
      if (cur_loaded && gap_left == 0) begin
        in_op          <= cur_item.op;
        in_pos_x       <= cur_item.key[15:0];
        in_pos_y       <= cur_item.key[31:16];
        in_rect_height <= cur_item.key[47:32];
        in_rect_length <= cur_item.key[63:48];
        start          <= 1'b1;
        cur_loaded     = 1'b0;
      end else begin
        // drop start and put junk on the payload; the block must ignore it
        start          <= 1'b0;
        in_op          <= 1'($urandom);
        in_pos_x       <= 16'($urandom);
        in_pos_y       <= 16'($urandom);
        in_rect_height <= 16'($urandom);
        in_rect_length <= 16'($urandom);
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: sample on the rising edge. Check any result against the oldest
  // expectation first, then predict the item taken at this edge.
  always @(posedge clk) begin : monitor
    set_result_t want;
    item_taken = rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: status %0d slot %0d count %0d",
                   out_status, out_slot, out_count);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_slot !== want.slot ||
            out_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                     want.status, want.slot, want.count, out_status, out_slot, out_count);
        end
      end
    end
    if (item_taken) begin
      expected_results.push_back(apply_key_op(in_op,
          {in_rect_length, in_rect_height, in_pos_y, in_pos_x}));
      items_taken++;
    end
    // Watchdog: give up when nothing moves for too long.
    if (item_taken || (rst_n && out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("unique_key_set_table_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] zero_key;
    logic [63:0] ones_key;
    logic [63:0] corner_a;
    logic [63:0] corner_b;
    logic [63:0] pick;
    logic [63:0] fill_keys[13];
    logic [63:0] pool[POOL_SIZE];
    logic        pick_op;
    int          n;
    int          idle_pct;
    int          insert_pct;
    int          roll;

    zero_key = '0;
    ones_key = '1;
    corner_a = {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};  // x min, y max, h 0, l max
    corner_b = {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};  // x max, y min, h max, l 0

    // Directed: empty remove, extremes, duplicate, middle remove, near miss,
    // fill to full, full reject, duplicate on full, top and bottom removes.
    add_item(ukst_pkg::OP_REMOVE, zero_key, 0);
    add_item(ukst_pkg::OP_INSERT, zero_key, 0);
    add_item(ukst_pkg::OP_INSERT, ones_key, 0);
    add_item(ukst_pkg::OP_INSERT, corner_a, 0);
    add_item(ukst_pkg::OP_INSERT, corner_b, 0);
    add_item(ukst_pkg::OP_INSERT, zero_key, 0);
    add_item(ukst_pkg::OP_REMOVE, ones_key, 0);
    add_item(ukst_pkg::OP_REMOVE, corner_a ^ 64'h0001_0000_0000_0000, 0);
    for (n = 0; n < 13; n++) begin
      fill_keys[n] = {16'hA5A0 + 16'(n), 16'(3 * n + 3), 16'(-(n + 1)), 16'(n + 1)};
      add_item(ukst_pkg::OP_INSERT, fill_keys[n], 0);
    end
    add_item(ukst_pkg::OP_INSERT, ones_key, 0);
    add_item(ukst_pkg::OP_INSERT, fill_keys[12], 0);
    add_item(ukst_pkg::OP_REMOVE, fill_keys[12], 0);
    add_item(ukst_pkg::OP_REMOVE, zero_key, 0);

    // Random: mostly keys from a small pool so hits, duplicates and full are
    // common; some single-bit near misses and some fully random keys.
    for (n = 0; n < POOL_SIZE; n++) pool[n] = {$urandom, $urandom};
    insert_pct = 60;
    for (n = 0; n < RAND_ITEMS; n++) begin
      case (n * 4 / RAND_ITEMS)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        2:       idle_pct = 0;   // no back-pressure on results, so run flat out
        default: idle_pct = 11;
      endcase
      // Swing the insert share so the set both fills up and drains.
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          2:       insert_pct = 80;
          default: insert_pct = 95;
        endcase
      end
      if (n % 300 == 299) pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
      roll = $urandom_range(99);
      pick = pool[$urandom_range(POOL_SIZE - 1)];
      if (roll >= 95) pick = {$urandom, $urandom};
      else if (roll >= 85) pick = pick ^ (64'd1 << $urandom_range(63));
      pick_op = ($urandom_range(99) < insert_pct) ? ukst_pkg::OP_INSERT
                                                  : ukst_pkg::OP_REMOVE;
      add_item(pick_op, pick, idle_pct);
    end
    items_total = item_queue.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: wait for every item to be taken and every result to arrive.
    while (items_taken < items_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("unique_key_set_table_tb: done, clean");
    end else begin
      $display("unique_key_set_table_tb: done, errors");
    end
    $finish;
  end

endmodule
